/* hw/rtl/spq_pkg.sv */
// Shared types and constants of the stable priority queue.
package spq_pkg;

	localparam logic [2:0] PRIO_MIN = 3'd1;
	localparam logic [2:0] PRIO_MAX = 3'd5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		RC_OK       = 2'd0,
		RC_BAD_PRIO = 2'd1,
		RC_FULL     = 2'd2,
		RC_EMPTY    = 2'd3
	} spq_rc_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT
	} spq_state_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic write;
		logic scan;
		logic first;
		logic shift;
	} spq_ctl_t;

endpackage

/* hw/rtl/spq_if.sv */
// Request and response channel interfaces of the stable priority queue.
interface spq_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] ticket_id;
	logic [2:0]  priority_req;
	logic [2:0]  ticket_status;

	modport source(output valid, operation, ticket_id, priority_req, ticket_status,
		input ready);
	modport sink(input valid, operation, ticket_id, priority_req, ticket_status,
		output ready);
endinterface

interface spq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_code;
	logic [15:0] out_id;
	logic [2:0]  out_priority;
	logic [2:0]  out_status;
	logic [4:0]  entry_count;

	modport source(output valid, result_code, out_id, out_priority, out_status,
		entry_count, input ready);
	modport sink(input valid, result_code, out_id, out_priority, out_status,
		entry_count, output ready);
endinterface

/* hw/rtl/spq_cell.sv */
// One queue cell: holds an entry and carries the best-so-far link of the search.
module spq_cell import spq_pkg::*; #(
	parameter int unsigned IDX_W = 4,
	parameter int unsigned ID_W  = 16,
	parameter int unsigned INDEX = 0
) (
	input  logic             clk,
	input  spq_ctl_t         ctl,
	input  logic [IDX_W-1:0] pos,
	input  logic [IDX_W-1:0] sel,
	input  logic [ID_W-1:0]  wr_id,
	input  logic [2:0]       wr_prio,
	input  logic [2:0]       wr_stat,
	input  logic [ID_W-1:0]  nxt_id,
	input  logic [2:0]       nxt_prio,
	input  logic [2:0]       nxt_stat,
	input  logic [ID_W-1:0]  lk_in_id,
	input  logic [2:0]       lk_in_prio,
	input  logic [2:0]       lk_in_stat,
	input  logic [IDX_W-1:0] lk_in_idx,
	output logic [ID_W-1:0]  ent_id,
	output logic [2:0]       ent_prio,
	output logic [2:0]       ent_stat,
	output logic [ID_W-1:0]  lk_id,
	output logic [2:0]       lk_prio,
	output logic [2:0]       lk_stat,
	output logic [IDX_W-1:0] lk_idx
);

	localparam logic [IDX_W-1:0] INDEX_C = IDX_W'(INDEX);

	logic [ID_W-1:0]  id_q;
	logic [2:0]       prio_q;
	logic [2:0]       stat_q;
	logic [ID_W-1:0]  lk_id_q;
	logic [2:0]       lk_prio_q;
	logic [2:0]       lk_stat_q;
	logic [IDX_W-1:0] lk_idx_q;
	logic             hit;
	logic             take_own;

	assign hit = (pos == INDEX_C);
	// Ties go to this cell: it is older than anything behind it.
	assign take_own = ctl.first || (prio_q <= lk_in_prio);

	always_ff @(posedge clk) begin
		if (ctl.write && hit) begin
			id_q   <= wr_id;
			prio_q <= wr_prio;
			stat_q <= wr_stat;
		end else if (ctl.shift && (INDEX_C >= sel)) begin
			id_q   <= nxt_id;
			prio_q <= nxt_prio;
			stat_q <= nxt_stat;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan && hit) begin
			if (take_own) begin
				lk_id_q   <= id_q;
				lk_prio_q <= prio_q;
				lk_stat_q <= stat_q;
				lk_idx_q  <= INDEX_C;
			end else begin
				lk_id_q   <= lk_in_id;
				lk_prio_q <= lk_in_prio;
				lk_stat_q <= lk_in_stat;
				lk_idx_q  <= lk_in_idx;
			end
		end
	end

	assign ent_id   = id_q;
	assign ent_prio = prio_q;
	assign ent_stat = stat_q;
	assign lk_id    = lk_id_q;
	assign lk_prio  = lk_prio_q;
	assign lk_stat  = lk_stat_q;
	assign lk_idx   = lk_idx_q;

endmodule

/* hw/rtl/stable_priority_queue_unit.sv */
// Top level of the stable priority queue: cell row and request sequencer.
//
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | operation, ticket_id, priority_req, ticket_status
//  rsp     | out | valid/ready  | result_code, out_id, out_priority, out_status, entry_count
//
// Insert and any rejected request: response registered in the cycle after acceptance.
// Remove on a non-empty queue: the search token walks the cell row from the newest
// entry to the oldest, one cell a cycle, then the shift step closes the gap and
// registers the response. A new request is taken once the sequencer is idle and the
// response register is free or being drained. A stalled response holds the
// sequencer in its gap-closing step. Reset clears the count and the handshake state.
module stable_priority_queue_unit import spq_pkg::*; #(
	parameter int unsigned DEPTH   = 16,
	parameter int unsigned ID_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	spq_state_t state_q, state_d;
	spq_ctl_t   ctl;

	logic [CNT_W-1:0] count_q, count_d, cnt_m1;
	logic [IDX_W-1:0] pos_q, pos_d, pos_bus;

	logic             rsp_valid_q;
	logic [1:0]       rsp_code_q, rsp_code_d;
	logic [15:0]      rsp_id_q, rsp_id_d;
	logic [2:0]       rsp_prio_q, rsp_prio_d;
	logic [2:0]       rsp_stat_q, rsp_stat_d;
	logic [4:0]       rsp_cnt_q;
	logic             ld_rsp;

	logic             out_free, req_fire, prio_ok, is_full;
	logic [31:0]      id_ext, lid_ext, cnt_ext;
	logic [ID_BITS-1:0] wr_id;

	logic [ID_BITS-1:0] ent_id  [DEPTH];
	logic [2:0]         ent_prio[DEPTH];
	logic [2:0]         ent_stat[DEPTH];
	logic [ID_BITS-1:0] lk_id   [DEPTH];
	logic [2:0]         lk_prio [DEPTH];
	logic [2:0]         lk_stat [DEPTH];
	logic [IDX_W-1:0]   lk_idx  [DEPTH];

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign req_fire  = req.valid && req.ready;
	assign prio_ok   = (req.priority_req >= PRIO_MIN) && (req.priority_req <= PRIO_MAX);
	assign is_full   = (count_q >= CNT_W'(DEPTH));
	assign cnt_m1    = count_q - CNT_W'(1);
	assign id_ext    = 32'(req.ticket_id);
	assign wr_id     = id_ext[ID_BITS-1:0];
	assign lid_ext   = 32'(lk_id[0]);
	assign pos_bus   = (state_q == ST_SCAN) ? pos_q : count_q[IDX_W-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire && (req.operation == OP_REMOVE) && (count_q != '0))
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (pos_q == '0)
					state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		ctl        = '0;
		ld_rsp     = 1'b0;
		count_d    = count_q;
		pos_d      = pos_q;
		rsp_code_d = RC_OK;
		rsp_id_d   = '0;
		rsp_prio_d = '0;
		rsp_stat_d = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req.operation == OP_INSERT) begin
						ld_rsp = 1'b1;
						if (!prio_ok) begin
							rsp_code_d = RC_BAD_PRIO;
						end else if (is_full) begin
							rsp_code_d = RC_FULL;
						end else begin
							ctl.write = 1'b1;
							count_d   = count_q + CNT_W'(1);
						end
					end else if (count_q == '0) begin
						ld_rsp     = 1'b1;
						rsp_code_d = RC_EMPTY;
					end else begin
						pos_d = cnt_m1[IDX_W-1:0];
					end
				end
			end
			ST_SCAN: begin
				ctl.scan  = 1'b1;
				ctl.first = (pos_q == cnt_m1[IDX_W-1:0]);
				if (pos_q != '0)
					pos_d = pos_q - IDX_W'(1);
			end
			ST_SHIFT: begin
				if (out_free) begin
					// Close the gap behind the winner and report it
					ctl.shift  = 1'b1;
					ld_rsp     = 1'b1;
					count_d    = cnt_m1;
					rsp_id_d   = lid_ext[15:0];
					rsp_prio_d = lk_prio[0];
					rsp_stat_d = lk_stat[0];
				end
			end
			default: ;
		endcase
	end

	assign cnt_ext = 32'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (ld_rsp)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		if (ld_rsp) begin
			rsp_code_q <= rsp_code_d;
			rsp_id_q   <= rsp_id_d;
			rsp_prio_q <= rsp_prio_d;
			rsp_stat_q <= rsp_stat_d;
			rsp_cnt_q  <= cnt_ext[4:0];
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_code  = rsp_code_q;
	assign rsp.out_id       = rsp_id_q;
	assign rsp.out_priority = rsp_prio_q;
	assign rsp.out_status   = rsp_stat_q;
	assign rsp.entry_count  = rsp_cnt_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ID_BITS-1:0] n_id, l_id;
		logic [2:0]         n_prio, n_stat, l_prio, l_stat;
		logic [IDX_W-1:0]   l_idx;

		if (i < DEPTH - 1) begin : g_mid
			assign n_id   = ent_id[i+1];
			assign n_prio = ent_prio[i+1];
			assign n_stat = ent_stat[i+1];
			assign l_id   = lk_id[i+1];
			assign l_prio = lk_prio[i+1];
			assign l_stat = lk_stat[i+1];
			assign l_idx  = lk_idx[i+1];
		end else begin : g_end
			assign n_id   = '0;
			assign n_prio = '0;
			assign n_stat = '0;
			assign l_id   = '0;
			assign l_prio = '0;
			assign l_stat = '0;
			assign l_idx  = '0;
		end

		spq_cell #(
			.IDX_W (IDX_W),
			.ID_W  (ID_BITS),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.pos        (pos_bus),
			.sel        (lk_idx[0]),
			.wr_id      (wr_id),
			.wr_prio    (req.priority_req),
			.wr_stat    (req.ticket_status),
			.nxt_id     (n_id),
			.nxt_prio   (n_prio),
			.nxt_stat   (n_stat),
			.lk_in_id   (l_id),
			.lk_in_prio (l_prio),
			.lk_in_stat (l_stat),
			.lk_in_idx  (l_idx),
			.ent_id     (ent_id[i]),
			.ent_prio   (ent_prio[i]),
			.ent_stat   (ent_stat[i]),
			.lk_id      (lk_id[i]),
			.lk_prio    (lk_prio[i]),
			.lk_stat    (lk_stat[i]),
			.lk_idx     (lk_idx[i])
		);
	end

endmodule

/* tb/sv/spq_result_checker.sv */
// Response checker for the stable priority queue: predicts each request and compares responses.
`timescale 1ns / 1ps
module spq_result_checker import spq_pkg::*; #(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	spq_req_if          req,
	spq_rsp_if          rsp,
	output int unsigned mismatch_count,
	output int unsigned pending_count
);

	typedef struct packed {
		spq_rc_t     code;
		logic [15:0] id;
		logic [2:0]  prio;
		logic [2:0]  stat;
		logic [4:0]  count;
	} ticket_result_t;

	localparam int unsigned REPORT_LIMIT = 10;

	// Shadow copy of the queue, oldest entry at index zero.
	logic [15:0]    shadow_id   [DEPTH];
	logic [2:0]     shadow_prio [DEPTH];
	logic [2:0]     shadow_stat [DEPTH];
	int unsigned    shadow_count;

	ticket_result_t awaited_q [$];
	int unsigned    fault_tally;

	function automatic ticket_result_t apply_request(input logic op, input logic [15:0] id,
			input logic [2:0] prio, input logic [2:0] stat);
		ticket_result_t r;
		int unsigned    best;
		r = '0;
		r.code = RC_OK;
		if (op == OP_INSERT) begin
			if (prio < PRIO_MIN || prio > PRIO_MAX) begin
				r.code = RC_BAD_PRIO;
			end else if (shadow_count >= DEPTH) begin
				r.code = RC_FULL;
			end else begin
				shadow_id[shadow_count]   = id;
				shadow_prio[shadow_count] = prio;
				shadow_stat[shadow_count] = stat;
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			r.code = RC_EMPTY;
		end else begin
			// Strict less-than keeps the oldest among equal priorities.
			best = 0;
			for (int unsigned i = 1; i < shadow_count; i++) begin
				if (shadow_prio[i] < shadow_prio[best])
					best = i;
			end
			r.id   = shadow_id[best];
			r.prio = shadow_prio[best];
			r.stat = shadow_stat[best];
			for (int unsigned i = best; i + 1 < shadow_count; i++) begin
				shadow_id[i]   = shadow_id[i + 1];
				shadow_prio[i] = shadow_prio[i + 1];
				shadow_stat[i] = shadow_stat[i + 1];
			end
			shadow_count--;
		end
		r.count = 5'(shadow_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ticket_result_t got;
		ticket_result_t want;
		if (!arst_n) begin
			awaited_q.delete();
			shadow_count   = 0;
			fault_tally    = 0;
			mismatch_count <= 0;
			pending_count  <= 0;
		end else begin
			// Check the response first: it can never belong to this cycle's request.
			if (rsp.valid && rsp.ready) begin
				got.code  = spq_rc_t'(rsp.result_code);
				got.id    = rsp.out_id;
				got.prio  = rsp.out_priority;
				got.stat  = rsp.out_status;
				got.count = rsp.entry_count;
				if (awaited_q.size() == 0) begin
					if (fault_tally < REPORT_LIMIT)
						$display("%0t: response with none awaited: code=%0d id=%h prio=%0d stat=%0d count=%0d",
							$realtime, got.code, got.id, got.prio, got.stat, got.count);
					fault_tally++;
				end else begin
					want = awaited_q.pop_front();
					if (got !== want) begin
						if (fault_tally < REPORT_LIMIT)
							$display("%0t: mismatch: expected code=%0d id=%h prio=%0d stat=%0d count=%0d, got code=%0d id=%h prio=%0d stat=%0d count=%0d",
								$realtime, want.code, want.id, want.prio, want.stat, want.count,
								got.code, got.id, got.prio, got.stat, got.count);
						fault_tally++;
					end
				end
			end
			if (req.valid && req.ready)
				awaited_q.push_back(apply_request(req.operation, req.ticket_id,
					req.priority_req, req.ticket_status));
			mismatch_count <= fault_tally;
			pending_count  <= awaited_q.size();
		end
	end

endmodule

/* tb/sv/tb_stable_priority_queue_unit.sv */
// Top of the stable priority queue testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_stable_priority_queue_unit import spq_pkg::*; ();

	localparam int unsigned DEPTH        = 16;
	localparam int unsigned PHASE_ITEMS  = 312;
	localparam int unsigned SETTLE_WAIT  = 2 * DEPTH + 8;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sink_ready = 1'b0;
	idle_mode_t  idle_mode = IDLE_NONE;
	int unsigned mismatch_count;
	int unsigned pending_count;

	spq_req_if req();
	spq_rsp_if rsp();

	assign rsp.ready = sink_ready;

	always #6 clk = ~clk;

	stable_priority_queue_unit #(
		.DEPTH   (DEPTH),
		.ID_BITS (16)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	spq_result_checker #(
		.DEPTH (DEPTH)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	function automatic int unsigned send_gap_pct(input idle_mode_t m);
		case (m)
			IDLE_SEND: return 82;
			IDLE_BOTH: return 36;
			default:   return 0;
		endcase
	endfunction

	function automatic int unsigned sink_stall_pct(input idle_mode_t m);
		case (m)
			IDLE_RECV: return 82;
			IDLE_BOTH: return 36;
			default:   return 0;
		endcase
	endfunction

	always @(posedge clk)
		sink_ready <= ($urandom_range(99) >= sink_stall_pct(idle_mode));

	task automatic send_request(input logic op, input logic [15:0] id, input logic [2:0] prio,
			input logic [2:0] stat);
		int unsigned gap_pct;
		gap_pct = send_gap_pct(idle_mode);
		if ($urandom_range(99) < gap_pct) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		req.valid         <= 1'b1;
		req.operation     <= op;
		req.ticket_id     <= id;
		req.priority_req  <= prio;
		req.ticket_status <= stat;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// Hold off new requests until every awaited response is back.
	task automatic wait_for_drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic run_random(input int unsigned items);
		int unsigned insert_pct;
		int unsigned band_lo;
		logic        narrow;
		logic        op;
		logic [2:0]  prio;
		insert_pct = 50;
		band_lo    = 1;
		narrow     = 1'b0;
		for (int unsigned n = 0; n < items; n++) begin
			// Move the fill bias every burst so the queue swings between empty and full.
			if (n % 32 == 0) begin
				case ($urandom_range(4))
					0:       insert_pct = 10;
					1:       insert_pct = 30;
					2:       insert_pct = 55;
					3:       insert_pct = 75;
					default: insert_pct = 92;
				endcase
				narrow  = 1'($urandom_range(1));
				band_lo = $urandom_range(1, 4);
			end
			op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
			if ($urandom_range(99) < 8) begin
				case ($urandom_range(2))
					0:       prio = 3'd0;
					1:       prio = 3'd6;
					default: prio = 3'd7;
				endcase
			end else if (narrow) begin
				prio = 3'(band_lo + $urandom_range(1));
			end else begin
				prio = 3'($urandom_range(PRIO_MAX, PRIO_MIN));
			end
			send_request(op, 16'($urandom), prio, 3'($urandom));
		end
	endtask

	initial begin
		logic [2:0] fill_prio [DEPTH];
		fill_prio = '{3'd3, 3'd3, 3'd5, 3'd1, 3'd1, 3'd2, 3'd4, 3'd5,
			3'd3, 3'd2, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3, 3'd4};
		req.valid         <= 1'b0;
		req.operation     <= OP_INSERT;
		req.ticket_id     <= '0;
		req.priority_req  <= '0;
		req.ticket_status <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty remove, rejected priorities, fill to full, overflow, removals.
		send_request(OP_REMOVE, 16'hFFFF, 3'd7, 3'd7);
		send_request(OP_INSERT, 16'h0000, 3'd0, 3'd0);
		send_request(OP_INSERT, 16'hFFFF, 3'd6, 3'd7);
		send_request(OP_INSERT, 16'h1234, 3'd7, 3'd5);
		for (int unsigned i = 0; i < DEPTH; i++) begin
			case (i)
				0:       send_request(OP_INSERT, 16'h0000, fill_prio[i], 3'd0);
				1:       send_request(OP_INSERT, 16'hFFFF, fill_prio[i], 3'd7);
				2:       send_request(OP_INSERT, 16'hA5A5, fill_prio[i], 3'd2);
				3:       send_request(OP_INSERT, 16'h5A5A, fill_prio[i], 3'd5);
				default: send_request(OP_INSERT, 16'(16'h1000 * i + i), fill_prio[i], 3'(i));
			endcase
		end
		send_request(OP_INSERT, 16'hBEEF, 3'd1, 3'd3);
		send_request(OP_INSERT, 16'hCAFE, 3'd0, 3'd1);
		send_request(OP_REMOVE, 16'h0000, 3'd0, 3'd0);
		send_request(OP_REMOVE, 16'hFFFF, 3'd7, 3'd7);
		send_request(OP_REMOVE, 16'h0F0F, 3'd3, 3'd4);
		wait_for_drain();

		idle_mode <= IDLE_NONE;
		run_random(PHASE_ITEMS);
		wait_for_drain();
		idle_mode <= IDLE_SEND;
		run_random(PHASE_ITEMS);
		wait_for_drain();
		idle_mode <= IDLE_RECV;
		run_random(PHASE_ITEMS);
		wait_for_drain();
		idle_mode <= IDLE_BOTH;
		run_random(PHASE_ITEMS);
		wait_for_drain();

		if (mismatch_count == 0 && pending_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#6ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
